FILE: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and sizes for the double-ended queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // Queue sizing
  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;

  // Fixed field widths of the stream words
  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int IN_FIELDS_W  = MODE_W + DATA_W;
  localparam int OUT_FIELDS_W = DATA_W + STATUS_W + COUNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Bits a cell keeps: the word is cut to the narrower of the two widths
  localparam int CELL_W = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_PEEK_BACK  = 3'd4,
    MODE_PEEK_FRONT = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic push_front;  // every cell takes its left neighbor's word
    logic pop_front;   // every cell takes its right neighbor's word
    logic push_back;   // the cell at the back slot loads the new word
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue chain; shifts toward either neighbor or loads.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell
  import deq_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic              at_back,
  input  wire logic [CELL_W-1:0] load_word,
  input  wire logic [CELL_W-1:0] left_word,
  input  wire logic [CELL_W-1:0] right_word,
  output logic      [CELL_W-1:0] word
);

  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      word <= left_word;
    end else if (ctrl.pop_front) begin
      word <= right_word;
    end else if (ctrl.push_back && at_back) begin
      word <= load_word;
    end
  end

endmodule

`default_nettype wire

FILE: src/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue built as a chain of shifting storage cells.
// ----------------------------------------------------------------------------
// Each input word carries one operation (push, pop or peek at either end, or
// clear) and produces exactly one output word holding the popped or peeked
// data, a status and the fill count after the operation. The front of the
// queue always sits in cell 0: a push or pop at the front shifts the whole
// chain by one cell, a push at the back loads the cell just past the last
// occupied one, and the back word is read from the cell picked
// by the fill count. An operation completes in the cycle it is accepted and
// its result appears on the output register the next cycle, so the core takes
// one word per clock whenever the output is drained; the output register is
// the only buffer, and the input stalls only while that register holds a
// result that the downstream side has not taken. After reset the queue is
// empty and ready at once; stored words need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_core
  import deq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // s_axis_tdata fields, low bit up: mode[2:0], data_in[34:3], zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // m_axis_tdata fields, low bit up: data_out[31:0], status[33:32],
  // count[38:34], zero fill
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Input word split
  mode_t              mode;
  logic [DATA_W-1:0]  data_in;
  logic               in_fire;

  // Queue state
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   fill_next;
  logic [CELL_W-1:0]  cell_word [DEPTH];
  logic [CELL_W-1:0]  load_word;
  logic [IDX_W-1:0]   back_idx;
  logic               full;
  logic               empty;
  cell_ctrl_t         op_ctrl;
  cell_ctrl_t         cell_ctrl;

  // Result of the current operation
  logic [CELL_W-1:0]  rd_word;
  status_t            rd_status;

  // Output register
  logic [DATA_W-1:0]  data_out;
  status_t            status;
  logic [COUNT_W-1:0] count;

  assign mode      = mode_t'(s_axis_tdata[MODE_W-1:0]);
  assign data_in   = s_axis_tdata[MODE_W +: DATA_W];
  assign load_word = data_in[CELL_W-1:0];

  // Take a new word whenever the output register is empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  // Last occupied cell; only used when the queue is not empty
  assign back_idx = IDX_W'(fill - CNT_W'(1));

  // Decode the operation
  always_comb begin
    op_ctrl   = '0;
    fill_next = fill;
    rd_word   = '0;
    rd_status = ST_OK;
    case (mode)
      MODE_PUSH_BACK: begin
        if (full) begin
          rd_status = ST_FULL;
        end else begin
          op_ctrl.push_back = 1'b1;
          fill_next         = fill + CNT_W'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          rd_status = ST_FULL;
        end else begin
          op_ctrl.push_front = 1'b1;
          fill_next          = fill + CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          rd_status = ST_EMPTY;
        end else begin
          // Drop the back word by shrinking the fill; the cell keeps its data
          rd_word   = cell_word[back_idx];
          fill_next = fill - CNT_W'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          rd_status = ST_EMPTY;
        end else begin
          rd_word           = cell_word[0];
          op_ctrl.pop_front = 1'b1;
          fill_next         = fill - CNT_W'(1);
        end
      end
      MODE_PEEK_BACK: begin
        if (empty) begin
          rd_status = ST_EMPTY;
        end else begin
          rd_word = cell_word[back_idx];
        end
      end
      MODE_PEEK_FRONT: begin
        if (empty) begin
          rd_status = ST_EMPTY;
        end else begin
          rd_word = cell_word[0];
        end
      end
      MODE_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        // Unused code: report ok and leave the queue alone
      end
    endcase
  end

  // Only move the chain on an accepted word
  assign cell_ctrl = in_fire ? op_ctrl : '0;

  // Cell chain: cell 0 is the front, data enters it on a front push
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CELL_W-1:0] left_word;
    logic [CELL_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = load_word;
    end else begin : g_inner_left
      assign left_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      // Vacated after a front pop from a full queue; contents are don't-care
      assign right_word = '0;
    end else begin : g_inner_right
      assign right_word = cell_word[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .at_back    (fill == CNT_W'(i)),
      .load_word  (load_word),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (cell_word[i])
    );
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (in_fire) begin
      fill <= fill_next;
    end
  end

  // Output register: hold until taken, load on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_out <= DATA_W'(rd_word);
      status   <= rd_status;
      count    <= COUNT_W'(fill_next);
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({count, status, data_out});

endmodule

`default_nettype wire

FILE: src/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue core.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker
  import deq_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [DATA_W-1:0]   chk_data;
  logic [STATUS_W-1:0] chk_status;
  logic [COUNT_W-1:0]  chk_count;

  assign chk_data   = m_axis_tdata[DATA_W-1:0];
  assign chk_status = m_axis_tdata[DATA_W +: STATUS_W];
  assign chk_count  = m_axis_tdata[DATA_W + STATUS_W +: COUNT_W];

  // A result waiting on a stalled output holds its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Every accepted input yields a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word gave no result");

  // A failed operation returns no data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (chk_status != ST_OK) |-> chk_data == '0)
    else $error("data on a failed operation");

  // Status codes stay in range and the count never passes the depth
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (chk_status != 2'd3) && (chk_count <= COUNT_W'(DEPTH)))
    else $error("status or count out of range");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);

`default_nettype wire
